>>> rtl/core/dgsp_pkg.sv
// shared types and constants for the dense graph shortest path core
// no dependencies
package dgsp_pkg;

  localparam int DIST_W = 17;
  localparam int PRED_W = 5;
  localparam int VIDX_W = 4;
  localparam int CNT_W = 5;
  localparam int VERTEX_SPAN = 16;

  localparam logic [DIST_W-1:0] NO_EDGE = 17'd100000;
  localparam logic [PRED_W-1:0] PRED_NONE = 5'h1f;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_RUN = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic init_step;
    logic scan_clear;
    logic scan_step;
    logic lock_best;
    logic relax_step;
    logic emit_step;
    logic emit_last;
    logic [VIDX_W-1:0] idx;
    logic [VIDX_W-1:0] start_vertex;
  } ctrl_t;

  typedef struct packed {
    logic found;
    logic [VIDX_W-1:0] best_vertex;
  } status_t;

endpackage

>>> rtl/core/dgsp_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module dgsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dgsp_seq.sv
// sequencer: run state machine, step counter and weight memory read address
// depends on dgsp_pkg
module dgsp_seq #(
  parameter int MAX_NODES = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic                                         opcode,
  input  logic [dgsp_pkg::VIDX_W-1:0]                  start_vertex,
  input  logic [dgsp_pkg::CNT_W-1:0]                   node_count,
  input  dgsp_pkg::status_t                            status,
  output logic                                         busy,
  output dgsp_pkg::ctrl_t                              ctrl,
  output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]       raddr
);
  import dgsp_pkg::*;

  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int LIM = (MAX_NODES < VERTEX_SPAN) ? MAX_NODES : VERTEX_SPAN;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [VIDX_W-1:0] sv;
  logic [CNT_W-1:0] nv;
  logic [CNT_W-1:0] eff;
  logic [VIDX_W-1:0] nm1;
  logic [VIDX_W-1:0] rd_row;
  logic accept;
  logic run_ok;

  always_comb begin
    if (node_count == '0) begin
      eff = CNT_W'(1);
    end else if (node_count > LIM_C) begin
      eff = LIM_C;
    end else begin
      eff = node_count;
    end
  end

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign run_ok = accept && (opcode_t'(opcode) == OP_RUN) && ({1'b0, start_vertex} < eff);
  assign nm1 = VIDX_W'(nv - CNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (run_ok) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (cnt == nv) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == nv - CNT_W'(1)) state_next = ST_PICK;
      end
      ST_PICK: begin
        state_next = status.found ? ST_RELAX : ST_EMIT;
      end
      ST_RELAX: begin
        if (cnt == nv) state_next = ST_SCAN;
      end
      ST_EMIT: begin
        if (cnt == nv - CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.start_vertex = sv;
    ctrl.idx = cnt[VIDX_W-1:0];
    rd_row = sv;
    case (state)
      ST_IDLE: begin
      end
      ST_INIT: begin
        ctrl.idx = cnt[VIDX_W-1:0] - VIDX_W'(1);
        ctrl.init_step = (cnt != '0);
        ctrl.scan_clear = (cnt == nv);
      end
      ST_SCAN: begin
        ctrl.scan_step = 1'b1;
      end
      ST_PICK: begin
        ctrl.lock_best = status.found;
      end
      ST_RELAX: begin
        rd_row = status.best_vertex;
        ctrl.idx = cnt[VIDX_W-1:0] - VIDX_W'(1);
        ctrl.relax_step = (cnt != '0);
        ctrl.scan_clear = (cnt == nv);
      end
      ST_EMIT: begin
        ctrl.emit_step = (cnt[VIDX_W-1:0] != sv);
        ctrl.emit_last = (cnt[VIDX_W-1:0] == nm1) ||
                         ((cnt[VIDX_W-1:0] == nm1 - VIDX_W'(1)) && (sv == nm1));
      end
      default: begin
      end
    endcase
  end

  assign raddr = AW'(32'(rd_row) * MAX_NODES + 32'(cnt[VIDX_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_ok) begin
      sv <= start_vertex;
      nv <= eff;
    end
  end

endmodule

>>> rtl/core/dgsp_dpath.sv
// datapath: distance, predecessor and locked tables, shared add and compare unit,
// result register; depends on dgsp_pkg
module dgsp_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  dgsp_pkg::ctrl_t                    ctrl,
  input  logic [dgsp_pkg::DIST_W-1:0]        rdata,
  output dgsp_pkg::status_t                  status,
  output logic                               strobe,
  output logic [dgsp_pkg::VIDX_W-1:0]        vertex,
  output logic [dgsp_pkg::DIST_W-1:0]        distance,
  output logic signed [dgsp_pkg::PRED_W-1:0] predecessor,
  output logic                               last
);
  import dgsp_pkg::*;

  logic [DIST_W-1:0] dist_tbl [VERTEX_SPAN];
  logic [PRED_W-1:0] pred [VERTEX_SPAN];
  logic [VERTEX_SPAN-1:0] locked;
  logic [DIST_W-1:0] best;
  logic [VIDX_W-1:0] best_vertex;
  logic found;

  logic [DIST_W-1:0] dcur;
  logic [DIST_W:0] cand;
  logic [DIST_W:0] op_a;
  logic [DIST_W:0] op_b;
  logic lt;

  // one comparator serves both the scan and the relaxation; the adder forms the relaxation candidate
  always_comb begin
    dcur = dist_tbl[ctrl.idx];
    cand = {1'b0, best} + {1'b0, rdata};
    if (ctrl.relax_step) begin
      op_a = cand;
      op_b = {1'b0, dcur};
    end else begin
      op_a = {1'b0, dcur};
      op_b = {1'b0, best};
    end
    lt = (op_a < op_b);
  end

  assign status.found = found;
  assign status.best_vertex = best_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= '0;
      found <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit_step;
      if (ctrl.init_step) begin
        locked[ctrl.idx] <= (ctrl.idx == ctrl.start_vertex);
      end
      if (ctrl.lock_best) begin
        locked[best_vertex] <= 1'b1;
      end
      if (ctrl.scan_clear) begin
        found <= 1'b0;
      end else if (ctrl.scan_step && !locked[ctrl.idx] && lt) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init_step) begin
      dist_tbl[ctrl.idx] <= rdata;
      if ((ctrl.idx != ctrl.start_vertex) && (rdata < NO_EDGE)) begin
        pred[ctrl.idx] <= {1'b0, ctrl.start_vertex};
      end else begin
        pred[ctrl.idx] <= PRED_NONE;
      end
    end
    if (ctrl.relax_step && !locked[ctrl.idx] && (rdata != NO_EDGE) && lt) begin
      dist_tbl[ctrl.idx] <= cand[DIST_W-1:0];
      pred[ctrl.idx] <= {1'b0, best_vertex};
    end
    if (ctrl.scan_clear) begin
      best <= NO_EDGE;
    end else if (ctrl.scan_step && !locked[ctrl.idx] && lt) begin
      best <= dcur;
      best_vertex <= ctrl.idx;
    end
    if (ctrl.emit_step) begin
      vertex <= ctrl.idx;
      distance <= dcur;
      predecessor <= pred[ctrl.idx];
      last <= ctrl.emit_last;
    end
  end

endmodule

>>> rtl/core/dense_graph_shortest_path_core.sv
// top level of the dense graph shortest path core
// depends on dgsp_pkg, dgsp_ram, dgsp_seq, dgsp_dpath
//
// usage:
//   an item is taken when start is high and busy is low. opcode 0 writes one
//   edge weight at row, col (weights above 100000 are stored as 100000, the
//   no-edge mark) and gives no result. opcode 1 runs the search from
//   start_vertex over the first node_count vertices (0 counts as 1, at most
//   MAX_NODES and 16); a run is ignored unless start_vertex is below that.
//   a run gives one result per vertex other than the start, in vertex order,
//   each on the result ports for one cycle with strobe high; last marks the
//   final one. the receiver cannot stall: results are never held. init and
//   relax steps read through the one read port of the weight memory, and
//   scan and relax share the one compare unit, one vertex per cycle. busy
//   stays high for the whole run. node_count is written through cfg_valid,
//   cfg_ready, cfg_data; the user must write it only while idle, the block
//   does not enforce it. cfg_ready is always high. reset sets node_count to 16
//   and returns to idle; weight memory contents are undefined until written.
module dense_graph_shortest_path_core #(
  parameter int MAX_NODES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic [dgsp_pkg::VIDX_W-1:0]        row,
  input  logic [dgsp_pkg::VIDX_W-1:0]        col,
  input  logic [dgsp_pkg::DIST_W-1:0]        weight,
  input  logic [dgsp_pkg::VIDX_W-1:0]        start_vertex,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dgsp_pkg::CNT_W-1:0]         cfg_data,
  output logic                               strobe,
  output logic [dgsp_pkg::VIDX_W-1:0]        vertex,
  output logic [dgsp_pkg::DIST_W-1:0]        distance,
  output logic signed [dgsp_pkg::PRED_W-1:0] predecessor,
  output logic                               last
);
  import dgsp_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0] node_count;
  logic we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DIST_W-1:0] wdata;
  logic [DIST_W-1:0] rdata;
  ctrl_t ctrl;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  assign we = start && !busy && (opcode_t'(opcode) == OP_WRITE) &&
              (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
  assign waddr = AW'(32'(row) * MAX_NODES + 32'(col));
  assign wdata = (weight > NO_EDGE) ? NO_EDGE : weight;

  dgsp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(DEPTH)
  ) u_weights (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  dgsp_seq #(
    .MAX_NODES(MAX_NODES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .start_vertex(start_vertex),
    .node_count  (node_count),
    .status      (status),
    .busy        (busy),
    .ctrl        (ctrl),
    .raddr       (raddr)
  );

  dgsp_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .rdata      (rdata),
    .status     (status),
    .strobe     (strobe),
    .vertex     (vertex),
    .distance   (distance),
    .predecessor(predecessor),
    .last       (last)
  );

endmodule
